FILE: sv/vld_pkg.sv
package vld_pkg;

    // detector states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_HANG   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_HANG_DELAY = 2'd2;

    // input opcodes and report kinds
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic REP_LEVEL   = 1'b0;
    localparam logic REP_TIMEOUT = 1'b1;

    localparam int LEVEL_STEPS = 60;
    localparam longint unsigned STEP_RATIO = 64'd3827893632;
    localparam longint unsigned THR_MILLI  = 64'd4294967;

    typedef logic signed [6:0] level_t;
    localparam level_t LEVEL_FLOOR = -7'sd60;
    localparam level_t LEVEL_TOP   = 7'sd0;

    typedef logic [32:0] thr_t;
    typedef thr_t [LEVEL_STEPS-1:0] thr_table_t;

    // Build the descending -1 dB threshold ladder in Q0.32, last entry 0.001
    function automatic thr_table_t build_thresholds();
        thr_table_t tbl;
        longint unsigned t;
        t = 64'd1 << 32;
        for (int k = 0; k < LEVEL_STEPS; k++)
        begin
            if (k == LEVEL_STEPS - 1)
                t = THR_MILLI;
            else
                t = (t * STEP_RATIO + (64'd1 << 31)) >> 32;
            tbl[k] = t[32:0];
        end
        return tbl;
    endfunction

    localparam thr_table_t THR_TABLE = build_thresholds();

    // status of the level unit towards the controller
    typedef struct packed {
        logic   busy;
        logic   done;
        level_t level;
    } lvl_status_t;

endpackage

FILE: sv/vld_in_if.sv
interface vld_in_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          block_last;

    modport source (output valid, opcode, sample_value, block_last, input ready);
    modport sink   (input valid, opcode, sample_value, block_last, output ready);
endinterface

FILE: sv/vld_out_if.sv
interface vld_out_if ();
    logic              valid;
    logic              ready;
    logic              report_kind;
    logic signed [6:0] level_db;
    logic [1:0]        vox_state;
    logic              state_changed;

    modport source (output valid, report_kind, level_db, vox_state, state_changed,
                    input ready);
    modport sink   (input valid, report_kind, level_db, vox_state, state_changed,
                    output ready);
endinterface

FILE: sv/vox_level_detector_hang_top.sv
// Voice-operated switch with block level detector and hang timer.
//
// Channels: in_ch carries audio samples (opcode sample, block_last closes a block)
// and millisecond ticks (opcode tick); out_ch carries level reports at block end
// and timeout reports when the hang time runs out. Both transfer on valid & ready.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this.
// Input: a sample or tick is taken whenever in_ch.ready is high. The last sample
// of a block starts the level unit: a pass over the stored block, then a restoring
// division of the deviation sum by n squared, one quotient bit a cycle, then a
// walk down the threshold ladder. The result passes the done flag and then the
// output register; in_ch.ready is low over all of this.
//
// Output sits in a single register: while a report waits and the receiver stalls,
// in_ch.ready is held low for every item, whether it would report or not.
// Reset clears the open block, the state (idle) and all control registers; the
// sample store needs no clearing.
module vox_level_detector_hang_top
    import vld_pkg::*;
#(
    parameter int MAX_BLOCK   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    vld_in_if.sink      in_ch,
    vld_out_if.source   out_ch
);

    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SW = SAMPLE_BITS + CW;

    localparam logic PH_READY = 1'b0;
    localparam logic PH_LEVEL = 1'b1;

    logic                 phase_reg;
    logic                 enabled_reg;
    level_t               thr_reg;
    logic [15:0]          delay_reg;
    logic [CW-1:0]        count_reg;
    logic signed [SW-1:0] sum_reg;
    logic [1:0]           state_reg;
    logic [15:0]          ticks_reg;

    logic                 out_valid_reg;
    logic                 kind_reg;
    level_t               level_reg;
    logic [1:0]           vstate_reg;
    logic                 changed_reg;

    logic                 accept;
    logic                 room;
    logic                 store_we;
    logic                 start;
    logic [AW-1:0]        rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    lvl_status_t          status;
    level_t               cfg_thr;
    logic [15:0]          ticks_next;
    logic [15:0]          limit;
    logic [1:0]           state_next;

    assign in_ch.ready = (phase_reg == PH_READY) && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign room        = count_reg < CW'(MAX_BLOCK);
    assign store_we    = accept && enabled_reg && (in_ch.opcode == OP_SAMPLE) && room;
    assign start       = accept && enabled_reg && (in_ch.opcode == OP_SAMPLE)
                         && in_ch.block_last;

    // clamp the threshold write into the ladder range
    always_comb
    begin
        cfg_thr = level_t'(cfg_wdata[6:0]);
        if (cfg_thr < LEVEL_FLOOR)
            cfg_thr = LEVEL_FLOOR;
        else if (cfg_thr > LEVEL_TOP)
            cfg_thr = LEVEL_TOP;
    end

    assign ticks_next = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 1'b1;
    assign limit      = (delay_reg == 16'd0) ? 16'd1 : delay_reg;

    // state after a finished block
    always_comb
    begin
        state_next = state_reg;
        if (status.level > thr_reg)
            state_next = ST_ACTIVE;
        else if (state_reg == ST_ACTIVE)
            state_next = ST_HANG;
    end

    vld_store #(
        .DEPTH (MAX_BLOCK),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_ch.sample_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vld_level #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_level (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .n       (count_reg),
        .sum     (sum_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .status  (status)
    );

    // control: configuration, block fill, hang timer, reports
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_READY;
            enabled_reg   <= 1'b0;
            thr_reg       <= LEVEL_TOP;
            delay_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            state_reg     <= ST_IDLE;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ENABLE:
                    begin
                        enabled_reg <= cfg_wdata[0];
                        if (!cfg_wdata[0])
                        begin
                            count_reg <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_IDLE;
                            ticks_reg <= '0;
                        end
                    end
                    REG_THRESHOLD:  thr_reg   <= cfg_thr;
                    REG_HANG_DELAY: delay_reg <= cfg_wdata;
                    default:        ;
                endcase
            end

            if (accept && enabled_reg)
            begin
                if (in_ch.opcode == OP_TICK)
                begin
                    if (state_reg == ST_HANG)
                    begin
                        if (ticks_next >= limit)
                        begin
                            state_reg     <= ST_IDLE;
                            ticks_reg     <= '0;
                            out_valid_reg <= 1'b1;
                        end
                        else
                            ticks_reg <= ticks_next;
                    end
                end
                else
                begin
                    if (room)
                    begin
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + SW'(in_ch.sample_value);
                    end
                    if (in_ch.block_last)
                        phase_reg <= PH_LEVEL;
                end
            end

            if (phase_reg == PH_LEVEL && status.done)
            begin
                phase_reg     <= PH_READY;
                count_reg     <= '0;
                sum_reg       <= '0;
                state_reg     <= state_next;
                if (state_next != state_reg)
                    ticks_reg <= '0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // report payload
    always_ff @(posedge clk)
    begin
        if (accept && enabled_reg && in_ch.opcode == OP_TICK)
        begin
            kind_reg    <= REP_TIMEOUT;
            level_reg   <= LEVEL_FLOOR;
            vstate_reg  <= ST_IDLE;
            changed_reg <= 1'b1;
        end
        else if (phase_reg == PH_LEVEL && status.done)
        begin
            kind_reg    <= REP_LEVEL;
            level_reg   <= status.level;
            vstate_reg  <= state_next;
            changed_reg <= (state_next != state_reg);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.report_kind   = kind_reg;
    assign out_ch.level_db      = level_reg;
    assign out_ch.vox_state     = vstate_reg;
    assign out_ch.state_changed = changed_reg;

endmodule

FILE: sv/vld_store.sv
module vld_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = 10
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [WIDTH-1:0] rd_data
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    // write one sample
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/vld_level.sv
module vld_level
    import vld_pkg::*;
#(
    parameter int MAX_BLOCK   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]               n,
    input  logic signed [SAMPLE_BITS+$clog2(MAX_BLOCK+1)-1:0] sum,
    output logic [((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1)-1:0] rd_addr,
    input  logic signed [SAMPLE_BITS-1:0]                rd_data,
    output lvl_status_t                                  status
);

    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int AW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int EW  = SW + 1;
    localparam int DW  = 2 * CW + SAMPLE_BITS;
    localparam int F   = 33 - SAMPLE_BITS;
    localparam int XW  = DW + F;
    localparam int NW  = 2 * CW;
    localparam int RW  = NW + 1;
    localparam int DCW = $clog2(XW + 1);
    localparam int KW  = 6;

    localparam logic [1:0] LP_IDLE = 2'd0;
    localparam logic [1:0] LP_PASS = 2'd1;
    localparam logic [1:0] LP_DIV  = 2'd2;
    localparam logic [1:0] LP_SRCH = 2'd3;

    logic [1:0]           phase_reg;
    logic [CW-1:0]        idx_reg;
    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [EW-1:0] prod_reg, dev_reg;
    logic [DW-1:0]        acc_reg;
    logic [NW-1:0]        n2_reg;
    logic [XW-1:0]        quo_reg;
    logic [RW-1:0]        rem_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic [KW-1:0]        k_reg;
    logic                 done_reg;
    level_t               level_reg;

    logic                 issue;
    logic                 pass_end;
    logic signed [EW-1:0] prod_c, dev_c;
    logic [EW-1:0]        mag_c;
    logic [RW-1:0]        trial;
    logic                 ge;
    logic [KW-1:0]        k_idx;
    logic                 above;
    logic                 stop;

    assign rd_addr  = idx_reg[AW-1:0];
    assign issue    = (phase_reg == LP_PASS) && (idx_reg < n);
    assign pass_end = (phase_reg == LP_PASS) && !(idx_reg < n)
                      && !v1_reg && !v2_reg && !v3_reg;

    // deviation pipeline: n*x, minus sum, magnitude
    assign prod_c = $signed({1'b0, n}) * rd_data;
    assign dev_c  = prod_reg - $signed({sum[SW-1], sum});
    assign mag_c  = dev_reg[EW-1] ? (~dev_reg + 1'b1) : dev_reg;

    // one restoring division step by n squared
    assign trial = {rem_reg[RW-2:0], quo_reg[XW-1]};
    assign ge    = trial >= {1'b0, n2_reg};

    // threshold ladder walk
    assign k_idx = (k_reg < KW'(LEVEL_STEPS)) ? k_reg : '0;
    assign above = quo_reg > XW'(THR_TABLE[k_idx]);
    assign stop  = (k_reg == KW'(LEVEL_STEPS)) || above;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LP_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            unique case (phase_reg)
                LP_IDLE:
                begin
                    if (start)
                        phase_reg <= LP_PASS;
                end
                LP_PASS:
                begin
                    if (pass_end)
                        phase_reg <= LP_DIV;
                end
                LP_DIV:
                begin
                    if (dcnt_reg == DCW'(1))
                        phase_reg <= LP_SRCH;
                end
                LP_SRCH:
                begin
                    if (stop)
                    begin
                        phase_reg <= LP_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: phase_reg <= LP_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (v1_reg)
            prod_reg <= prod_c;
        if (v2_reg)
            dev_reg <= dev_c;
        unique case (phase_reg)
            LP_IDLE:
            begin
                idx_reg <= '0;
                acc_reg <= '0;
            end
            LP_PASS:
            begin
                n2_reg <= NW'(n) * NW'(n);
                if (issue)
                    idx_reg <= idx_reg + 1'b1;
                if (v3_reg)
                    acc_reg <= acc_reg + DW'(mag_c);
                quo_reg  <= XW'(acc_reg) << F;
                rem_reg  <= '0;
                dcnt_reg <= DCW'(XW);
            end
            LP_DIV:
            begin
                rem_reg  <= ge ? (trial - {1'b0, n2_reg}) : trial;
                quo_reg  <= {quo_reg[XW-2:0], ge};
                dcnt_reg <= dcnt_reg - 1'b1;
                k_reg    <= '0;
            end
            LP_SRCH:
            begin
                if (stop)
                    level_reg <= level_t'(-$signed({1'b0, k_reg}));
                else
                    k_reg <= k_reg + 1'b1;
            end
            default: idx_reg <= '0;
        endcase
    end

    assign status.busy  = (phase_reg != LP_IDLE);
    assign status.done  = done_reg;
    assign status.level = level_reg;

endmodule

FILE: sv/vld_checker.sv
module vld_checker
    import vld_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_kind,
    input logic [6:0]  out_level,
    input logic [1:0]  out_state,
    input logic        out_changed
);

    // a stalled report blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while report stalled");

    // a timeout report always says floor level, idle, changed
    a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == REP_TIMEOUT) |->
        (out_level == LEVEL_FLOOR && out_state == ST_IDLE && out_changed))
        else $error("malformed timeout report");

    // a stalled report holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(out_kind) && $stable(out_level)
         && $stable(out_state) && $stable(out_changed)))
        else $error("stalled report changed");

endmodule

bind vox_level_detector_hang_top vld_checker u_vld_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.report_kind),
    .out_level   (out_ch.level_db),
    .out_state   (out_ch.vox_state),
    .out_changed (out_ch.state_changed)
);
